// ----- rtl/core/lneb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Line editor package
// Character codes, register indexes, reset values and sequencer states that
// the line editor uses.
// ----------------------------------------------------------------------------
package lneb_pkg;

    localparam int BYTE_W    = 8;
    localparam int CAP_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 2'd1;

    localparam logic             ECHO_RESET = 1'b1;
    localparam logic [CAP_W-1:0] CAP_RESET  = 6'd32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_NL_ECHO,
        S_RD,
        S_LINE,
        S_TERM
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/line_editor_with_backspace.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor
// Edits a line of received bytes with backspace and echo, and streams the
// finished line with a zero terminator when a newline arrives.
// ----------------------------------------------------------------------------
// Received bytes are taken only in the idle state. An ordinary byte or a
// backspace gives at most one echo request, issued from the S_EMIT state into
// a single output register once that register is free. A newline is slower:
// an optional echo, then every stored byte, because each byte is read from the
// line memory through its one registered read port (S_RD) before it is loaded
// into the output register (S_LINE), and finally the terminator. A new byte is
// accepted in the idle state even while a result still waits in the output
// register. Configuration writes are always accepted and should only be made
// while the block is idle.
module line_editor_with_backspace
    import lneb_pkg::*;
#(
    parameter int MAX_LINE = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [BYTE_W-1:0]    i_s_tdata,    // [7:0] rx_byte
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [BYTE_W-1:0]         o_m_tdata,    // [7:0] out_byte
    output logic                      o_m_tuser,    // [0] to_sender
    output logic                      o_m_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CAP_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam int CMP_W = CAP_W + 1;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_LINE);

    t_state r_state, n_state;

    logic             r_echo;
    logic [CAP_W-1:0] r_cap;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;

    logic [BYTE_W-1:0] r_mem [MAX_LINE];
    logic [BYTE_W-1:0] r_rd_data;
    logic              mem_we;
    logic              mem_re;

    logic [BYTE_W-1:0] r_pend, n_pend;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_user;
    logic              r_out_last;
    logic              out_load;
    logic [BYTE_W-1:0] out_data;
    logic              out_user;
    logic              out_last;
    logic              out_free;

    logic              s_acc;
    logic              is_nl;
    logic              is_bs;
    logic [CMP_W-1:0]  eff_cap;
    logic              room;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign is_nl       = (i_s_tdata == CH_NL);
    assign is_bs       = (i_s_tdata == CH_DEL) || (i_s_tdata == CH_BS);
    assign out_free    = !r_out_valid || i_m_tready;

    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if ({1'b0, r_cap} > MAX_CMP) begin
            eff_cap = MAX_CMP;
        end else begin
            eff_cap = {1'b0, r_cap};
        end
        room = (CMP_W'(r_count) + CMP_W'(1)) < eff_cap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= ECHO_RESET;
            r_cap  <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ECHO_ENABLE:   r_echo <= i_cfg_data[0];
                CFG_LINE_CAPACITY: r_cap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count] <= i_s_tdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        n_pend   = r_pend;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        out_load = 1'b0;
        out_data = CH_NUL;
        out_user = 1'b0;
        out_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (is_nl) begin
                        n_rd_idx = '0;
                        n_state  = r_echo ? S_NL_ECHO : S_RD;
                    end else if (is_bs) begin
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                            n_pend  = CH_BS;
                            if (r_echo) begin
                                n_state = S_EMIT;
                            end
                        end
                    end else begin
                        if (room) begin
                            mem_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                        n_pend = i_s_tdata;
                        if (r_echo) begin
                            n_state = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = r_pend;
                    out_user = 1'b1;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_NL_ECHO: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = CH_NL;
                    out_user = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_RD: begin
                if (r_rd_idx < r_count) begin
                    mem_re  = 1'b1;
                    n_state = S_LINE;
                end else begin
                    n_state = S_TERM;
                end
            end
            S_LINE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = r_rd_data;
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                    n_state  = S_RD;
                end
            end
            S_TERM: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = CH_NUL;
                    out_last = 1'b1;
                    n_count  = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_idx <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_data;
            r_out_user <= out_user;
            r_out_last <= out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) < MAX_CMP)
        else $error("Fill count has reached the line size.");

    a_nl_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && is_nl) |=> (r_state != S_IDLE))
        else $error("A newline request did not start the line output.");

    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast && !o_m_tuser) |-> (o_m_tdata == CH_NUL))
        else $error("Line terminator is not zero.");

    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> (r_rd_idx < r_count))
        else $error("Line memory read beyond the fill count.");

endmodule
`default_nettype wire
